// File: hdl/usb_sof_timing_monitor_defines.svh
// Assertion macros used by the SOF timing monitor checker.
`ifndef USB_SOF_TIMING_MONITOR_DEFINES_SVH
`define USB_SOF_TIMING_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define USM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usm check failed");

// Next-cycle implication, disabled in reset.
`define USM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("usm check failed");

`endif

// File: hdl/usm_pkg.sv
// Types and constants of the SOF timing monitor.
`timescale 1ns / 1ps
`default_nettype none
package usm_pkg;
  localparam int ANOMALY_WORDS = 7;
  localparam int IDX_W = 6;

  // Offsets of the fixed words that follow the histogram.
  localparam logic [3:0] WRD_RACE     = 4'd0;
  localparam logic [3:0] WRD_ANOM     = 4'd1;
  localparam logic [3:0] WRD_RFRAME   = 4'd2;
  localparam logic [3:0] WRD_RTIME    = 4'd3;
  localparam logic [3:0] WRD_MF_LO    = 4'd4;
  localparam logic [3:0] WRD_MF_HI    = 4'd5;
  localparam logic [3:0] WRD_MIN      = 4'd6;
  localparam logic [3:0] WRD_MAX      = 4'd7;
  localparam logic [3:0] WRD_SUM_LO   = 4'd8;
  localparam logic [3:0] WRD_SUM_HI   = 4'd9;
  localparam logic [3:0] WRD_COUNT    = 4'd10;
  localparam logic [3:0] WRD_FILL     = 4'd11;

  typedef struct packed {
    logic capture;
    logic sof;
    logic drain_init;
    logic advance;
    logic clear;
  } usm_cmd_t;

  typedef struct packed {
    logic op_drain;
    logic last;
  } usm_sts_t;
endpackage
`default_nettype wire

// File: hdl/usb_sof_timing_monitor.sv
// Top level of the USB start-of-frame timing monitor.
`timescale 1ns / 1ps
`default_nettype none
// Takes one transaction at a time. A SOF transaction is captured in S_IDLE;
// in S_EXEC the datapath then updates counters, histogram, interval
// statistics and the anomaly record in a single step. A drain transaction
// is captured, set up in S_EXEC, then sends one output word per cycle while
// out_stall is low, HIST_BUCKETS + 13 + 7 * fill words in all; the controller
// walks the word index through the drain multiplexer. No clearing pass follows reset.
module usb_sof_timing_monitor import usm_pkg::*; #(
  parameter int HIST_BUCKETS  = 8,
  parameter int ANOMALY_SLOTS = 4,
  parameter int FRAME_BITS    = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [13:0] frame_entry,
  input  wire logic [13:0] frame_second_read,
  input  wire logic [31:0] timestamp,
  input  wire logic [31:0] usb_status,
  input  wire logic [31:0] port_status,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      word,
  output logic [5:0]       word_index,
  output logic             last
);
  usm_cmd_t cmd;
  usm_sts_t sts;

  usm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  usm_dp #(
    .HIST_BUCKETS(HIST_BUCKETS), .ANOMALY_SLOTS(ANOMALY_SLOTS), .FRAME_BITS(FRAME_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .sts, .operation, .frame_entry, .frame_second_read,
    .timestamp, .usb_status, .port_status, .word, .word_index, .last
  );
endmodule
`default_nettype wire

// File: hdl/usm_ctrl.sv
// Controller state machine of the SOF timing monitor.
`timescale 1ns / 1ps
`default_nettype none
module usm_ctrl import usm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire usm_sts_t sts,
  output usm_cmd_t      cmd
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op_drain) begin
          cmd.drain_init = 1'b1;
          state_next     = S_DRAIN;
        end else begin
          cmd.sof    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DRAIN: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.advance = 1'b1;
          // clear interval stats and anomaly fill count once the final word goes
          if (sts.last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/usm_dp.sv
// Datapath of the SOF timing monitor: counters, statistics and drain mux.
`timescale 1ns / 1ps
`default_nettype none
module usm_dp import usm_pkg::*; #(
  parameter int HIST_BUCKETS  = 8,
  parameter int ANOMALY_SLOTS = 4,
  parameter int FRAME_BITS    = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire usm_cmd_t    cmd,
  output usm_sts_t         sts,
  input  wire logic        operation,
  input  wire logic [13:0] frame_entry,
  input  wire logic [13:0] frame_second_read,
  input  wire logic [31:0] timestamp,
  input  wire logic [31:0] usb_status,
  input  wire logic [31:0] port_status,
  output logic [31:0]      word,
  output logic [5:0]       word_index,
  output logic             last
);
  localparam int HBW = $clog2(HIST_BUCKETS);
  localparam int SLW = (ANOMALY_SLOTS > 1) ? $clog2(ANOMALY_SLOTS) : 1;
  localparam int FB  = FRAME_BITS;

  // captured transaction
  logic            op_r;
  logic [FB-1:0]   f1_r, f2_r;
  logic [31:0]     ts_r, us_r, ps_r;

  logic [31:0]     sof_total, race_total, anomaly_count;
  logic [31:0]     delta_hist [HIST_BUCKETS];
  logic [2:0]      anomaly_fill;
  logic [31:0]     anomaly_store [ANOMALY_SLOTS][ANOMALY_WORDS];
  logic [FB-1:0]   recent_frame, prior_frame;
  logic [31:0]     recent_time, prior_time;
  logic [63:0]     microframe_total, gap_sum;
  logic            prior_valid;
  logic [31:0]     gap_min, gap_max, gap_count;

  logic [IDX_W-1:0] idx;
  logic [SLW-1:0]   rd_slot;
  logic [2:0]       rd_word;

  logic [FB-1:0]   delta;
  logic [31:0]     gap;
  logic [HBW-1:0]  bucket;
  logic            anomaly, store_ok;
  logic [IDX_W-1:0] last_idx, rel_full;
  logic [3:0]       rel;
  logic             in_store;

  assign delta  = f1_r - prior_frame;
  assign gap    = ts_r - prior_time;
  assign bucket = (delta < FB'(HIST_BUCKETS - 1)) ? delta[HBW-1:0] : HBW'(HIST_BUCKETS - 1);
  assign anomaly  = (delta != FB'(1));
  assign store_ok = (anomaly_fill < 3'(ANOMALY_SLOTS));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= operation;
      f1_r <= frame_entry[FB-1:0];
      f2_r <= frame_second_read[FB-1:0];
      ts_r <= timestamp;
      us_r <= usb_status;
      ps_r <= port_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sof_total        <= '0;
      race_total       <= '0;
      anomaly_count    <= '0;
      anomaly_fill     <= '0;
      recent_frame     <= '0;
      recent_time      <= '0;
      microframe_total <= '0;
      prior_frame      <= '0;
      prior_time       <= '0;
      prior_valid      <= 1'b0;
      gap_min          <= 32'hFFFF_FFFF;
      gap_max          <= '0;
      gap_sum          <= '0;
      gap_count        <= '0;
      idx              <= '0;
      rd_slot          <= '0;
      rd_word          <= '0;
      for (int i = 0; i < HIST_BUCKETS; i++) delta_hist[i] <= '0;
    end else begin
      if (cmd.sof) begin
        sof_total    <= sof_total + 32'd1;
        recent_frame <= f1_r;
        recent_time  <= ts_r;
        prior_frame  <= f1_r;
        prior_time   <= ts_r;
        prior_valid  <= 1'b1;
        if (f2_r != f1_r) race_total <= race_total + 32'd1;
        if (prior_valid) begin
          delta_hist[bucket] <= delta_hist[bucket] + 32'd1;
          microframe_total   <= microframe_total + 64'(delta);
          if (gap < gap_min) gap_min <= gap;
          if (gap > gap_max) gap_max <= gap;
          gap_sum   <= gap_sum + 64'(gap);
          gap_count <= gap_count + 32'd1;
          if (anomaly) begin
            anomaly_count <= anomaly_count + 32'd1;
            if (store_ok) anomaly_fill <= anomaly_fill + 3'd1;
          end
        end
      end
      if (cmd.drain_init) begin
        idx     <= '0;
        rd_slot <= '0;
        rd_word <= '0;
      end else if (cmd.advance) begin
        idx <= idx + 6'd1;
        if (in_store) begin
          if (rd_word == 3'(ANOMALY_WORDS - 1)) begin
            rd_word <= '0;
            rd_slot <= rd_slot + SLW'(1);
          end else begin
            rd_word <= rd_word + 3'd1;
          end
        end
      end
      if (cmd.clear) begin
        gap_min      <= 32'hFFFF_FFFF;
        gap_max      <= '0;
        gap_sum      <= '0;
        gap_count    <= '0;
        anomaly_fill <= '0;
      end
    end
  end

  // record payload; no reset, read only for slots filled since the last drain
  always_ff @(posedge clk) begin
    if (cmd.sof && prior_valid && anomaly && store_ok) begin
      anomaly_store[anomaly_fill[SLW-1:0]][0] <= 32'(prior_frame);
      anomaly_store[anomaly_fill[SLW-1:0]][1] <= 32'(f1_r);
      anomaly_store[anomaly_fill[SLW-1:0]][2] <= 32'(delta);
      anomaly_store[anomaly_fill[SLW-1:0]][3] <= gap;
      anomaly_store[anomaly_fill[SLW-1:0]][4] <= us_r;
      anomaly_store[anomaly_fill[SLW-1:0]][5] <= ps_r;
      anomaly_store[anomaly_fill[SLW-1:0]][6] <= ts_r;
    end
  end

  assign last_idx = 6'(HIST_BUCKETS + 12) + 6'(anomaly_fill) * 6'(ANOMALY_WORDS);
  assign rel_full = idx - 6'(HIST_BUCKETS + 1);
  assign rel      = rel_full[3:0];
  assign in_store = (idx >= 6'(HIST_BUCKETS + 13));

  always_comb begin
    word = '0;
    if (idx == '0) begin
      word = sof_total;
    end else if (idx <= 6'(HIST_BUCKETS)) begin
      word = delta_hist[HBW'(idx - 6'd1)];
    end else if (in_store) begin
      word = anomaly_store[rd_slot][rd_word];
    end else begin
      case (rel)
        WRD_RACE:   word = race_total;
        WRD_ANOM:   word = anomaly_count;
        WRD_RFRAME: word = 32'(recent_frame);
        WRD_RTIME:  word = recent_time;
        WRD_MF_LO:  word = microframe_total[31:0];
        WRD_MF_HI:  word = microframe_total[63:32];
        WRD_MIN:    word = (gap_count == '0) ? 32'd0 : gap_min;
        WRD_MAX:    word = gap_max;
        WRD_SUM_LO: word = gap_sum[31:0];
        WRD_SUM_HI: word = gap_sum[63:32];
        WRD_COUNT:  word = gap_count;
        WRD_FILL:   word = 32'(anomaly_fill);
        default:    word = '0;
      endcase
    end
  end

  assign word_index   = idx;
  assign last         = (idx == last_idx);
  assign sts.op_drain = op_r;
  assign sts.last     = last;
endmodule
`default_nettype wire

// File: hdl/usm_checker.sv
// Port-level checker of the SOF timing monitor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "usb_sof_timing_monitor_defines.svh"
module usm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] word,
  input wire logic [5:0]  word_index,
  input wire logic        last
);
  // no new transaction is taken while a drain stream is out
  `USM_ASSERT_NOW(a_no_in_during_drain, out_valid, in_stall)
  // stream continues with the next index until its last word
  `USM_ASSERT_NEXT(a_index_step, out_valid && !out_stall && !last,
    out_valid && (word_index == $past(word_index) + 6'd1))
  // stream ends after its last word
  `USM_ASSERT_NEXT(a_end_after_last, out_valid && !out_stall && last, !out_valid)
  // stalled result holds
  `USM_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall,
    out_valid && $stable(word) && $stable(word_index))
endmodule

bind usb_sof_timing_monitor usm_checker u_usm_checker (.*);
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the USB start-of-frame timing monitor.
`timescale 1ns / 1ps
module tb;
  localparam int NBUCKET = 8;
  localparam int NSLOT = 4;
  localparam int REC_W = 7;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic        op;
    logic [13:0] f1;
    logic [13:0] f2;
    logic [31:0] ts;
    logic [31:0] ust;
    logic [31:0] pst;
  } sof_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  idx;
    logic        last;
  } drain_word_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic operation = 0;
  logic [13:0] frame_entry = 0, frame_second_read = 0;
  logic [31:0] timestamp = 0, usb_status = 0, port_status = 0;
  logic out_stall = 0;
  logic in_stall, out_valid, last;
  logic [31:0] word;
  logic [5:0] word_index;

  usb_sof_timing_monitor dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  sof_item_t pending[$];
  drain_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;
  int hold_off = 0;
  bit held = 0;
  int burst_left = 0, gap_left = 0;

  // monitor state copy
  logic [31:0] m_sof, m_race, m_anom, m_rtime, m_ptime, m_gmin, m_gmax, m_gcnt;
  logic [31:0] m_hist[NBUCKET];
  logic [13:0] m_rframe, m_pframe;
  logic [63:0] m_mf, m_gsum;
  logic        m_pvalid;
  int          m_fill;
  logic [31:0] m_store[NSLOT*REC_W];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic push_word(logic [31:0] w);
    drain_word_t d;
    d.word = w;
    d.idx = 6'(expected_words.size());
    d.last = 0;
    expected_words.push_back(d);
  endtask

  task automatic predict_monitor(sof_item_t it);
    logic [13:0] delta;
    logic [31:0] gap;
    int b, base;
    if (it.op) begin
      int start = expected_words.size();
      push_word(m_sof);
      for (int i = 0; i < NBUCKET; i++) push_word(m_hist[i]);
      push_word(m_race); push_word(m_anom); push_word(32'(m_rframe)); push_word(m_rtime);
      push_word(m_mf[31:0]); push_word(m_mf[63:32]);
      push_word(m_gcnt == 0 ? 32'd0 : m_gmin); push_word(m_gmax);
      push_word(m_gsum[31:0]); push_word(m_gsum[63:32]); push_word(m_gcnt);
      push_word(32'(m_fill));
      for (int i = 0; i < m_fill * REC_W; i++) push_word(m_store[i]);
      // indices are per stream
      for (int i = start; i < expected_words.size(); i++)
        expected_words[i].idx = 6'(i - start);
      expected_words[$].last = 1;
      m_gmin = '1; m_gmax = 0; m_gsum = 0; m_gcnt = 0; m_fill = 0;
      return;
    end
    m_sof++;
    m_rframe = it.f1;
    m_rtime = it.ts;
    if (it.f2 != it.f1) m_race++;
    if (!m_pvalid) begin
      m_pvalid = 1; m_pframe = it.f1; m_ptime = it.ts;
      return;
    end
    delta = it.f1 - m_pframe;
    gap = it.ts - m_ptime;
    m_pframe = it.f1; m_ptime = it.ts;
    b = delta < NBUCKET - 1 ? int'(delta) : NBUCKET - 1;
    m_hist[b]++;
    m_mf += 64'(delta);
    if (gap < m_gmin) m_gmin = gap;
    if (gap > m_gmax) m_gmax = gap;
    m_gsum += 64'(gap);
    m_gcnt++;
    if (delta == 1) return;
    m_anom++;
    if (m_fill >= NSLOT) return;
    base = m_fill * REC_W;
    m_store[base] = 32'(14'(it.f1 - delta));
    m_store[base+1] = 32'(it.f1);
    m_store[base+2] = 32'(delta);
    m_store[base+3] = gap;
    m_store[base+4] = it.ust;
    m_store[base+5] = it.pst;
    m_store[base+6] = it.ts;
    m_fill++;
  endtask

  // driver: bursts and gaps; holds payload while stalled
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) predict_monitor(pending.pop_front());
      if (in_valid && in_stall) begin
        // hold
      end else if (pending.size() > 0 && (burst_left > 0 || gap_left == 0)) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 20);
        burst_left--;
        if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        in_valid <= 1;
        operation <= pending[0].op;
        frame_entry <= pending[0].f1;
        frame_second_read <= pending[0].f2;
        timestamp <= pending[0].ts;
        usb_status <= pending[0].ust;
        port_status <= pending[0].pst;
      end else begin
        in_valid <= 0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern, with one long hold-off in the middle of a drain
  always @(posedge clk) begin
    cycles++;
    if (hold_off > 0) begin
      hold_off--;
      out_stall <= 1;
    end else if (!held && out_valid && cycles > 200) begin
      held = 1;
      hold_off = 400;
      out_stall <= 1;
    end else if ((cycles / 200) % 3 == 0) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    drain_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", word, 0);
      end else begin
        e = expected_words.pop_front();
        if (word !== e.word) report("word", word, e.word);
        if (word_index !== e.idx) report("word_index", 32'(word_index), 32'(e.idx));
        if (last !== e.last) report("last", 32'(last), 32'(e.last));
      end
    end
  end

  task automatic add_sof(logic [13:0] f1, logic [13:0] f2, logic [31:0] ts,
                         logic [31:0] u, logic [31:0] p);
    pending.push_back({1'b0, f1, f2, ts, u, p});
  endtask

  task automatic add_drain();
    sof_item_t it;
    it.op = 1'b1;
    it.f1 = 14'($urandom());
    it.f2 = 14'($urandom());
    it.ts = $urandom();
    it.ust = $urandom();
    it.pst = $urandom();
    pending.push_back(it);
  endtask

  initial begin
    logic [13:0] fr;
    logic [31:0] t;
    int n;
    m_sof = 0; m_race = 0; m_anom = 0; m_rtime = 0; m_ptime = 0; m_gmin = '1;
    m_gmax = 0; m_gcnt = 0; m_rframe = 0; m_pframe = 0; m_mf = 0; m_gsum = 0;
    m_pvalid = 0; m_fill = 0;
    for (int i = 0; i < NBUCKET; i++) m_hist[i] = 0;
    for (int i = 0; i < NSLOT*REC_W; i++) m_store[i] = 0;
    // directed: drain before any SOF, priming, wrap, races, big deltas, full store
    add_drain();
    add_sof(14'h3fff, 14'h3fff, 32'hffffff00, 32'hffffffff, 32'h0);
    add_drain();
    add_sof(14'h0, 14'h1, 32'h000001f4, 32'h0, 32'hffffffff);
    add_sof(14'h1, 14'h1, 32'h000003e8, 32'h5a5a5a5a, 32'ha5a5a5a5);
    add_sof(14'h1, 14'h2, 32'h000003e8, 32'h1, 32'h2);
    add_sof(14'h3, 14'h3, 32'h0, 32'h3, 32'h4);
    for (int d = 2; d < 12; d++) add_sof(14'(3 + d * 3), 14'(3 + d * 3), 32'(d * 500), d, d);
    add_sof(14'h2000, 14'h1fff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_drain();
    add_sof(14'h2001, 14'h2001, 32'h0, 32'h0, 32'h0);
    add_drain();
    add_drain();
    // random: mostly well-behaved frame sequences with occasional anomalies
    fr = 14'($urandom()); t = $urandom();
    n = 0;
    while (n < 440) begin
      if ($urandom_range(0, 24) == 0) begin
        add_drain();
      end else begin
        case ($urandom_range(0, 9))
          0: fr = 14'($urandom());
          1, 2: fr = fr + 14'($urandom_range(0, 9));
          default: fr = fr + 14'd1;
        endcase
        t = ($urandom_range(0, 9) == 0) ? $urandom() : t + $urandom_range(400, 600);
        add_sof(fr, ($urandom_range(0, 7) == 0) ? 14'($urandom()) : fr, t,
                $urandom(), $urandom());
      end
      n++;
    end
    add_drain();
    stim_done = 1;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    wait (stim_done && pending.size() == 0 && !in_valid && expected_words.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("Verification failed");
    $finish;
  end
endmodule
